// ===== src/assert_macros.svh =====
// assertion macros used by the binner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/pbtb_pkg.sv =====
// constants, types and helpers of the point tile binner
`timescale 1ns / 1ps

package pbtb_pkg;

  localparam int COORD_BITS = 32;
  localparam int TILE_BITS  = 7;
  localparam int MAX_TILES  = 64;
  localparam int CELL_BITS  = $clog2(MAX_TILES);
  localparam int ACC_BITS   = 2 * CELL_BITS;
  localparam int IDX_BITS   = 18;
  localparam int PROD_BITS  = COORD_BITS + TILE_BITS;
  localparam int STEP_BITS  = $clog2(TILE_BITS);
  localparam int AXES       = 3;
  localparam int AXIS_BITS  = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_TILES_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TILES_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_TILES_Z = CFG_IDX_BITS'(2);

  localparam logic OP_BOUND    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_CELL  = 9'b000100000,
    S_COMB1 = 9'b001000000,
    S_COMB2 = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // zero counts as one tile, large values saturate
  function automatic logic [TILE_BITS-1:0] eff_tiles(input logic [TILE_BITS-1:0] n);
    logic [TILE_BITS-1:0] r;
    if (n == '0) begin
      r = TILE_BITS'(1);
    end else if (n > TILE_BITS'(MAX_TILES)) begin
      r = TILE_BITS'(MAX_TILES);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// ===== src/point_bounding_box_tile_binner.sv =====
// top level: bounding box tracker and bit-serial tile classifier
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Every input transfer yields one result transfer. A bound item (op 0) grows or restarts the
// per-axis box and goes from S_CHECK straight to S_DONE; a classify item found outside the box
// takes the same path. A classify item inside the box instead runs each of the three axes in
// turn through one shared restoring divider that makes one quotient bit per cycle (operand
// setup, multiply by the tile count, 7 quotient bits, clamp), followed by the S_COMB1 and
// S_COMB2 states that fold the cells into the linear index. One item is worked on at a time;
// the next item is taken as soon as the previous result sits in the output register, even if
// that result has not yet been taken downstream. The user must write tile counts on the cfg
// channel only while the block is idle, which the block itself does not enforce; cfg_ready_o is
// always high.
module point_bounding_box_tile_binner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pbtb_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [pbtb_pkg::TILE_BITS-1:0]    cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic [1:0]  s_axis_tuser_i,   // op [0], first_point [1]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // tile_index [17:0], zero [23:18]
  output logic [1:0]  m_axis_tuser_o    // out_of_box [0], was_classify [1]
);

  localparam int CW = pbtb_pkg::COORD_BITS;
  localparam int TW = pbtb_pkg::TILE_BITS;
  localparam int PW = pbtb_pkg::PROD_BITS;

  pbtb_pkg::state_e state_q, state_d;

  logic [TW-1:0] tiles_x_q, tiles_y_q, tiles_z_q;
  logic [TW-1:0] n_x, n_y, n_z;

  logic                 op_q, first_q;
  logic signed [CW-1:0] pt_q [pbtb_pkg::AXES];
  logic signed [CW-1:0] lo_q [pbtb_pkg::AXES];
  logic signed [CW-1:0] hi_q [pbtb_pkg::AXES];
  logic                 box_valid_q;

  logic [pbtb_pkg::AXIS_BITS-1:0] ax_q;
  logic [CW-1:0]                  off_q, ext_q;
  logic [TW-1:0]                  n_q, q_q;
  logic                           zero_q;
  logic [PW-1:0]                  rem_q, div_q;
  logic [pbtb_pkg::STEP_BITS-1:0] step_q;
  logic [pbtb_pkg::CELL_BITS-1:0] cell_q [pbtb_pkg::AXES];
  logic [pbtb_pkg::ACC_BITS-1:0]  acc_q;

  logic [pbtb_pkg::IDX_BITS-1:0]  res_idx_q;
  logic                           res_oob_q;

  logic                           m_valid_q;
  logic [pbtb_pkg::IDX_BITS-1:0]  m_idx_q;
  logic                           m_oob_q, m_cls_q;

  logic                 accept;
  logic                 outside;
  logic                 restart;
  logic                 out_free;
  logic signed [CW-1:0] pt_sel, lo_sel, hi_sel;
  logic [TW-1:0]        n_sel;
  logic [PW:0]          trial;
  logic [TW-1:0]        cell_full;

  assign n_x = pbtb_pkg::eff_tiles(tiles_x_q);
  assign n_y = pbtb_pkg::eff_tiles(tiles_y_q);
  assign n_z = pbtb_pkg::eff_tiles(tiles_z_q);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == pbtb_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign restart         = first_q || !box_valid_q;

  always_comb begin
    outside = !box_valid_q;
    for (int i = 0; i < pbtb_pkg::AXES; i++) begin
      if (pt_q[i] < lo_q[i] || pt_q[i] > hi_q[i]) begin
        outside = 1'b1;
      end
    end
  end

  always_comb begin
    pt_sel = pt_q[ax_q];
    lo_sel = lo_q[ax_q];
    hi_sel = hi_q[ax_q];
    case (ax_q)
      pbtb_pkg::AXIS_BITS'(0): n_sel = n_x;
      pbtb_pkg::AXIS_BITS'(1): n_sel = n_y;
      default:                 n_sel = n_z;
    endcase
  end

  // one restoring step: subtract the shifted divisor when it fits
  assign trial = {1'b0, rem_q} - {1'b0, div_q};

  // quotient never exceeds n since offset <= extent; high face clamps to n-1
  assign cell_full = zero_q ? '0 : ((q_q >= n_q) ? n_q - TW'(1) : q_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbtb_pkg::S_IDLE:  if (accept) state_d = pbtb_pkg::S_CHECK;
      pbtb_pkg::S_CHECK: begin
        if (op_q == pbtb_pkg::OP_BOUND || outside) begin
          state_d = pbtb_pkg::S_DONE;
        end else begin
          state_d = pbtb_pkg::S_LOAD;
        end
      end
      pbtb_pkg::S_LOAD:  state_d = pbtb_pkg::S_MUL;
      pbtb_pkg::S_MUL:   state_d = pbtb_pkg::S_DIV;
      pbtb_pkg::S_DIV:   if (step_q == pbtb_pkg::STEP_BITS'(TW - 1)) state_d = pbtb_pkg::S_CELL;
      pbtb_pkg::S_CELL: begin
        if (ax_q == pbtb_pkg::AXIS_BITS'(pbtb_pkg::AXES - 1)) begin
          state_d = pbtb_pkg::S_COMB1;
        end else begin
          state_d = pbtb_pkg::S_LOAD;
        end
      end
      pbtb_pkg::S_COMB1: state_d = pbtb_pkg::S_COMB2;
      pbtb_pkg::S_COMB2: state_d = pbtb_pkg::S_DONE;
      pbtb_pkg::S_DONE:  if (out_free) state_d = pbtb_pkg::S_IDLE;
      default:           state_d = pbtb_pkg::S_IDLE;
    endcase
  end

  // control state, tile count registers and box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbtb_pkg::S_IDLE;
      tiles_x_q   <= TW'(1);
      tiles_y_q   <= TW'(1);
      tiles_z_q   <= TW'(1);
      box_valid_q <= 1'b0;
      for (int i = 0; i < pbtb_pkg::AXES; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
      ax_q        <= '0;
      step_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pbtb_pkg::REG_TILES_X: tiles_x_q <= cfg_data_i;
          pbtb_pkg::REG_TILES_Y: tiles_y_q <= cfg_data_i;
          pbtb_pkg::REG_TILES_Z: tiles_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == pbtb_pkg::S_CHECK && op_q == pbtb_pkg::OP_BOUND) begin
        box_valid_q <= 1'b1;
        for (int i = 0; i < pbtb_pkg::AXES; i++) begin
          if (restart || pt_q[i] < lo_q[i]) lo_q[i] <= pt_q[i];
          if (restart || pt_q[i] > hi_q[i]) hi_q[i] <= pt_q[i];
        end
      end
      if (state_q == pbtb_pkg::S_CHECK) begin
        ax_q <= '0;
      end else if (state_q == pbtb_pkg::S_CELL) begin
        ax_q <= ax_q + pbtb_pkg::AXIS_BITS'(1);
      end
      if (state_q == pbtb_pkg::S_MUL) begin
        step_q <= '0;
      end else if (state_q == pbtb_pkg::S_DIV) begin
        step_q <= step_q + pbtb_pkg::STEP_BITS'(1);
      end
      if (state_q == pbtb_pkg::S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tuser_i[0];
      first_q  <= s_axis_tuser_i[1];
      pt_q[0]  <= s_axis_tdata_i[CW-1:0];
      pt_q[1]  <= s_axis_tdata_i[2*CW-1:CW];
      pt_q[2]  <= s_axis_tdata_i[3*CW-1:2*CW];
    end
    if (state_q == pbtb_pkg::S_CHECK) begin
      res_idx_q <= '0;
      res_oob_q <= (op_q == pbtb_pkg::OP_CLASSIFY) && outside;
    end
    if (state_q == pbtb_pkg::S_LOAD) begin
      off_q <= CW'(pt_sel - lo_sel);
      ext_q <= CW'(hi_sel - lo_sel);
      n_q   <= n_sel;
    end
    if (state_q == pbtb_pkg::S_MUL) begin
      rem_q  <= PW'(off_q) * PW'(n_q);
      div_q  <= PW'(ext_q) << (TW - 1);
      zero_q <= (ext_q == '0);
      q_q    <= '0;
    end
    if (state_q == pbtb_pkg::S_DIV) begin
      if (!trial[PW]) rem_q <= trial[PW-1:0];
      q_q   <= {q_q[TW-2:0], !trial[PW]};
      div_q <= div_q >> 1;
    end
    if (state_q == pbtb_pkg::S_CELL) begin
      cell_q[ax_q] <= cell_full[pbtb_pkg::CELL_BITS-1:0];
    end
    if (state_q == pbtb_pkg::S_COMB1) begin
      acc_q <= pbtb_pkg::ACC_BITS'(cell_q[0]) * pbtb_pkg::ACC_BITS'(n_y)
             + pbtb_pkg::ACC_BITS'(cell_q[1]);
    end
    if (state_q == pbtb_pkg::S_COMB2) begin
      res_idx_q <= pbtb_pkg::IDX_BITS'(acc_q) * pbtb_pkg::IDX_BITS'(n_z)
                 + pbtb_pkg::IDX_BITS'(cell_q[2]);
    end
    if (state_q == pbtb_pkg::S_DONE && out_free) begin
      m_idx_q <= res_idx_q;
      m_oob_q <= res_oob_q;
      m_cls_q <= op_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(24 - pbtb_pkg::IDX_BITS){1'b0}}, m_idx_q};
  assign m_axis_tuser_o  = {m_cls_q, m_oob_q};

  `ASSERT_CLK(a_accept_to_check, accept |=> (state_q == pbtb_pkg::S_CHECK), "accept did not start check")
  `ASSERT_CLK(a_oob_zero_index, (m_valid_q && m_oob_q) |-> (m_idx_q == '0), "out-of-box result has nonzero index")
  `ASSERT_CLK(a_bound_result_zero, (m_valid_q && !m_cls_q) |-> (m_idx_q == '0 && !m_oob_q), "bound result not zero")
  `ASSERT_CLK(a_box_valid_stays, !$fell(box_valid_q), "box valid dropped")
  `ASSERT_CLK(a_cell_x_in_range, (state_q == pbtb_pkg::S_COMB1) |-> (TW'(cell_q[0]) < n_x), "x cell out of range")

endmodule

// ===== test/point_bounding_box_tile_binner_test.sv =====
// testbench for the point tile binner: predicted bins checked against every result transfer
`timescale 1ns / 1ps

module point_bounding_box_tile_binner_test;

  localparam int          RANDOM_ITEMS = 950;
  localparam int          QUIET_TAIL   = 150;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [31:0] C_MIN        = 32'h8000_0000;
  localparam logic [31:0] C_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] C_FIVE       = 32'h0005_0000;

  typedef struct {
    logic               op;
    logic               first_point;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } point_item_t;

  typedef struct {
    logic [17:0] tile_index;
    logic        out_of_box;
    logic        was_classify;
  } tile_result_t;

  class tile_binner_scoreboard;
    logic [pbtb_pkg::TILE_BITS-1:0] tiles_reg [3];
    longint               box_lo [3];
    longint               box_hi [3];
    bit                   box_valid;
    tile_result_t         pending_bins [$];
    int                   mismatch_count;

    function new();
      for (int a = 0; a < 3; a++) begin
        tiles_reg[a] = pbtb_pkg::TILE_BITS'(1);
        box_lo[a]    = 0;
        box_hi[a]    = 0;
      end
      box_valid      = 0;
      mismatch_count = 0;
    endfunction

    function void set_tiles(logic [pbtb_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [pbtb_pkg::TILE_BITS-1:0] value);
      case (idx)
        pbtb_pkg::REG_TILES_X: tiles_reg[0] = value;
        pbtb_pkg::REG_TILES_Y: tiles_reg[1] = value;
        pbtb_pkg::REG_TILES_Z: tiles_reg[2] = value;
        default: ;
      endcase
    endfunction

    // zero means one tile, anything past the maximum saturates
    function longint unsigned used_tiles(int axis);
      if (tiles_reg[axis] == 0) return 1;
      if (tiles_reg[axis] > pbtb_pkg::MAX_TILES) return pbtb_pkg::MAX_TILES;
      return tiles_reg[axis];
    endfunction

    function longint unsigned axis_cell(int axis, longint v);
      longint unsigned span;
      longint unsigned off;
      longint unsigned n;
      longint unsigned bin_cell;
      span = longint'(box_hi[axis] - box_lo[axis]);
      off  = longint'(v - box_lo[axis]);
      n    = used_tiles(axis);
      if (span == 0) return 0;
      bin_cell = (off * n) / span;
      if (bin_cell >= n) bin_cell = n - 1;
      return bin_cell;
    endfunction

    function void note_point(point_item_t p);
      longint          c [3];
      tile_result_t    r;
      bit              outside;
      longint unsigned linear;
      c[0] = p.coord_x;
      c[1] = p.coord_y;
      c[2] = p.coord_z;
      r.tile_index   = '0;
      r.out_of_box   = 1'b0;
      r.was_classify = 1'b0;
      if (p.op == pbtb_pkg::OP_BOUND) begin
        for (int a = 0; a < 3; a++) begin
          if (p.first_point || !box_valid) begin
            box_lo[a] = c[a];
            box_hi[a] = c[a];
          end else begin
            if (c[a] < box_lo[a]) box_lo[a] = c[a];
            if (c[a] > box_hi[a]) box_hi[a] = c[a];
          end
        end
        box_valid = 1;
      end else begin
        r.was_classify = 1'b1;
        outside = !box_valid;
        for (int a = 0; a < 3; a++) begin
          if (c[a] < box_lo[a] || c[a] > box_hi[a]) outside = 1;
        end
        if (outside) begin
          r.out_of_box = 1'b1;
        end else begin
          linear = axis_cell(0, c[0]) * used_tiles(1) * used_tiles(2)
                 + axis_cell(1, c[1]) * used_tiles(2) + axis_cell(2, c[2]);
          r.tile_index = linear[17:0];
        end
      end
      pending_bins.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_result(tile_result_t got);
      tile_result_t want;
      if (pending_bins.size() == 0) begin
        report_mismatch("result transfer with no point waiting");
      end else begin
        want = pending_bins.pop_front();
        if (got.tile_index !== want.tile_index)
          report_mismatch($sformatf("tile_index got %0d want %0d",
                                    got.tile_index, want.tile_index));
        if (got.out_of_box !== want.out_of_box)
          report_mismatch($sformatf("out_of_box got %b want %b",
                                    got.out_of_box, want.out_of_box));
        if (got.was_classify !== want.was_classify)
          report_mismatch($sformatf("was_classify got %b want %b",
                                    got.was_classify, want.was_classify));
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [pbtb_pkg::CFG_IDX_BITS-1:0] cfg_index_i;
  logic [pbtb_pkg::TILE_BITS-1:0]    cfg_data_i;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [95:0]             s_axis_tdata_i;   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  logic [1:0]              s_axis_tuser_i;   // op [0], first_point [1]
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [23:0]             m_axis_tdata_o;   // tile_index [17:0], zero [23:18]
  logic [1:0]              m_axis_tuser_o;   // out_of_box [0], was_classify [1]

  tile_binner_scoreboard binner;
  tile_result_t          seen_bin;
  bit                    idle_on;
  int                    items_sent;
  int unsigned           cycle_count;
  int                    stall_left;

  point_bounding_box_tile_binner dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic point_item_t mk_point(logic op, logic first, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
    point_item_t p;
    p.op          = op;
    p.first_point = first;
    p.coord_x     = x;
    p.coord_y     = y;
    p.coord_z     = z;
    return p;
  endfunction

  // base plus a random offset below 2**w
  function automatic logic [31:0] rand_axis(logic [31:0] base, int w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : ((32'h1 << w) - 32'h1);
    return base + ($urandom & mask);
  endfunction

  function automatic logic [31:0] point_within(int axis);
    longint unsigned span;
    longint unsigned r;
    span = longint'(binner.box_hi[axis] - binner.box_lo[axis]);
    r    = {$urandom, $urandom};
    return 32'(binner.box_lo[axis] + longint'(r % (span + 1)));
  endfunction

  function automatic logic [pbtb_pkg::TILE_BITS-1:0] pick_tiles();
    case ($urandom_range(0, 9))
      0:       return pbtb_pkg::TILE_BITS'(1);
      1:       return pbtb_pkg::TILE_BITS'(pbtb_pkg::MAX_TILES);
      2:       return '0;
      3:       return pbtb_pkg::TILE_BITS'($urandom_range(pbtb_pkg::MAX_TILES + 1, 127));
      default: return pbtb_pkg::TILE_BITS'($urandom_range(1, pbtb_pkg::MAX_TILES));
    endcase
  endfunction

  task automatic send_point(point_item_t p);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {p.coord_z, p.coord_y, p.coord_x};
    s_axis_tuser_i  = {p.first_point, p.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    binner.note_point(p);
    items_sent++;
  endtask

  task automatic write_tiles(logic [pbtb_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [pbtb_pkg::TILE_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    binner.set_tiles(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending and wait until every predicted bin has come back
  task automatic drain_bins();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (binner.pending_bins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i = 1'b0;
        stall_left      = $urandom_range(1, 18) - 1;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_bin.tile_index   = m_axis_tdata_o[17:0];
      seen_bin.out_of_box   = m_axis_tuser_o[0];
      seen_bin.was_classify = m_axis_tuser_o[1];
      binner.check_result(seen_bin);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int           random_end;
    int           n_bound;
    int           n_class;
    int           width [3];
    logic [31:0]  base [3];
    logic [31:0]  pt [3];
    int           axis;
    logic         first;

    binner          = new();
    idle_on         = 1'b1;
    items_sent      = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full grid, empty box, corners, zero extent, points just past a face on each axis
    write_tiles(pbtb_pkg::REG_TILES_X, pbtb_pkg::TILE_BITS'(pbtb_pkg::MAX_TILES));
    write_tiles(pbtb_pkg::REG_TILES_Y, pbtb_pkg::TILE_BITS'(pbtb_pkg::MAX_TILES));
    write_tiles(pbtb_pkg::REG_TILES_Z, pbtb_pkg::TILE_BITS'(pbtb_pkg::MAX_TILES));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 0, 0, 0));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b0, C_MIN, C_MIN, C_MIN));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b0, C_MAX, C_MAX, C_MAX));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_MAX, C_MAX, C_MAX));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b1, C_MIN, C_MIN, C_MIN));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 0, 32'hffff_ffff, 32'h4000_0000));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b1, C_FIVE, C_FIVE, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE, C_FIVE, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE + 1, C_FIVE, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE, C_FIVE - 1, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE, C_FIVE, C_FIVE + 1));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b0, -C_FIVE, C_FIVE + 100, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 0, C_FIVE + 50, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, -C_FIVE - 1, C_FIVE, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE, C_FIVE + 101, C_FIVE));
    drain_bins();
    // out of range tile counts
    write_tiles(pbtb_pkg::REG_TILES_X, '0);
    write_tiles(pbtb_pkg::REG_TILES_Y, pbtb_pkg::TILE_BITS'(127));
    write_tiles(pbtb_pkg::REG_TILES_Z, pbtb_pkg::TILE_BITS'(pbtb_pkg::MAX_TILES + 1));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, C_FIVE, C_FIVE + 100, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 0, C_FIVE + 99, C_FIVE));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b1, 32'hffff_ffff, 0, C_MIN));
    send_point(mk_point(pbtb_pkg::OP_BOUND, 1'b0, 1, C_MAX, 32'hffff_ffff));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 0, 32'h4000_0000, 32'hc000_0000));
    send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'b0, 32'hffff_ffff, C_MAX, C_MIN));

    // random: each phase sets the grid, grows or restarts a box, then mostly classifies in it
    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      drain_bins();
      idle_on = (items_sent < random_end - QUIET_TAIL) && ($urandom_range(0, 9) < 7);
      write_tiles(pbtb_pkg::REG_TILES_X, pick_tiles());
      write_tiles(pbtb_pkg::REG_TILES_Y, pick_tiles());
      write_tiles(pbtb_pkg::REG_TILES_Z, pick_tiles());
      for (int a = 0; a < 3; a++) begin
        base[a]  = $urandom;
        width[a] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
      end
      n_bound = $urandom_range(1, 6);
      for (int i = 0; i < n_bound; i++) begin
        first = (i == 0) && ($urandom_range(0, 7) != 0);
        send_point(mk_point(pbtb_pkg::OP_BOUND, first, rand_axis(base[0], width[0]),
                            rand_axis(base[1], width[1]), rand_axis(base[2], width[2])));
      end
      n_class = $urandom_range(5, 30);
      for (int i = 0; i < n_class; i++) begin
        for (int a = 0; a < 3; a++) pt[a] = point_within(a);
        axis = $urandom_range(0, 2);
        case ($urandom_range(0, 19))
          0: begin
            send_point(mk_point(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom));
          end
          1, 2: begin
            // just past one face
            pt[axis] = $urandom_range(0, 1) ? 32'(binner.box_hi[axis] + 1)
                                            : 32'(binner.box_lo[axis] - 1);
            send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'($urandom), pt[0], pt[1], pt[2]));
          end
          3, 4: begin
            for (int a = 0; a < 3; a++)
              pt[a] = $urandom_range(0, 1) ? 32'(binner.box_hi[a]) : 32'(binner.box_lo[a]);
            send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'($urandom), pt[0], pt[1], pt[2]));
          end
          default: begin
            send_point(mk_point(pbtb_pkg::OP_CLASSIFY, 1'($urandom), pt[0], pt[1], pt[2]));
          end
        endcase
      end
    end

    drain_bins();
    repeat (40) @(posedge clk_i);
    if (binner.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== point_bounding_box_tile_binner.f =====
+incdir+src
src/pbtb_pkg.sv
src/point_bounding_box_tile_binner.sv
test/point_bounding_box_tile_binner_test.sv
